FILE: rtl/deq_pkg.sv
// deq_pkg: shared types and defaults for the double-ended queue
// item structs, command and error codes, cell operation codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int WORD_BITS          = 32;
   localparam int COUNT_BITS         = 5;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_SHIFT_UP   = 2'd1,
      CELL_SHIFT_DOWN = 2'd2,
      CELL_LOAD       = 2'd3
   } cell_op_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [WORD_BITS-1:0]   data_in;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]   popped_value;
      logic [WORD_BITS-1:0]   front_value;
      logic [WORD_BITS-1:0]   back_value;
      logic                   is_empty;
      logic [COUNT_BITS-1:0]  entry_count;
      err_type                error_code;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/deq_cell.sv
// deq_cell: one storage cell of a deque chain
// holds one word, takes it from a neighbor, from the push word or keeps it
// depends on deq_pkg
`timescale 1ns / 1ps
`default_nettype none

module deq_cell
   import deq_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int CW         = COUNT_BITS,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire cell_op_type           op,
   input  wire logic [CW-1:0]         count,
   input  wire logic [DATA_WIDTH-1:0] word,
   input  wire logic [DATA_WIDTH-1:0] lower_q,
   input  wire logic [DATA_WIDTH-1:0] upper_q,
   output logic      [DATA_WIDTH-1:0] cell_q,
   output logic      [DATA_WIDTH-1:0] cell_d
);

   logic [DATA_WIDTH-1:0] slot_ff;
   logic [DATA_WIDTH-1:0] slot_in;

   always_comb begin
      unique case (op)
         CELL_HOLD:       slot_in = slot_ff;
         CELL_SHIFT_UP:   slot_in = lower_q;
         CELL_SHIFT_DOWN: slot_in = upper_q;
         CELL_LOAD:       slot_in = (count == CW'(INDEX)) ? word : slot_ff;
         default:         slot_in = slot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign cell_q = slot_ff;
   assign cell_d = slot_in;

endmodule

`default_nettype wire

FILE: rtl/deq_chain.sv
// deq_chain: row of deq_cell instances with the head at index zero
// shifts toward the tail, toward the head, or loads the push word at the count
// depends on deq_pkg and deq_cell
`timescale 1ns / 1ps
`default_nettype none

module deq_chain
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int CW         = COUNT_BITS
) (
   input  wire logic                  clock,
   input  wire cell_op_type           op,
   input  wire logic [CW-1:0]         count,
   input  wire logic [DATA_WIDTH-1:0] word,
   output logic      [DATA_WIDTH-1:0] head_q,
   output logic      [DATA_WIDTH-1:0] head_d
);

   logic [DATA_WIDTH-1:0] q_arr [DEPTH];
   logic [DATA_WIDTH-1:0] d_arr [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_q;
      logic [DATA_WIDTH-1:0] upper_q;

      if (i == 0) begin : g_first
         assign lower_q = word;
      end else begin : g_mid_lo
         assign lower_q = q_arr[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign upper_q = q_arr[i];
      end else begin : g_mid_hi
         assign upper_q = q_arr[i+1];
      end

      deq_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CW         (CW),
         .INDEX      (i)
      ) u_cell (
         .clock   (clock),
         .op      (op),
         .count   (count),
         .word    (word),
         .lower_q (lower_q),
         .upper_q (upper_q),
         .cell_q  (q_arr[i]),
         .cell_d  (d_arr[i])
      );
   end

   assign head_q = q_arr[0];
   assign head_d = d_arr[0];

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// double_ended_queue: bounded deque built from two chains of cells
// depends on deq_pkg and deq_chain
`timescale 1ns / 1ps
`default_nettype none

// The queue takes one item per clock cycle and returns its result item in the
// cycle after acceptance from an output register. The input stalls only while
// that register holds a result the receiver has not taken. Two rows of DEPTH
// cells hold the entries: one with the front word in its first cell, one with
// the back word in its first cell, so front, back and popped words come from
// fixed cells. A pop on an empty queue reports an underflow and a push on a
// full queue reports an overflow and drops the word; neither changes the
// contents. No clearing pass runs after reset.

module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic [DATA_WIDTH-1:0] word;
   cell_op_type           front_op;
   cell_op_type           back_op;
   err_type               err;
   logic [DATA_WIDTH-1:0] popped;
   logic [DATA_WIDTH-1:0] front_q;
   logic [DATA_WIDTH-1:0] front_d;
   logic [DATA_WIDTH-1:0] back_q;
   logic [DATA_WIDTH-1:0] back_d;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign word      = DATA_WIDTH'(req_data.data_in);

   always_comb begin
      front_op = CELL_HOLD;
      back_op  = CELL_HOLD;
      err      = ERR_OK;
      popped   = '0;
      count_in = count_ff;
      if (accept) begin
         unique case (req_data.cmd)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  err = ERR_FULL;
               end else begin
                  front_op = CELL_SHIFT_UP;
                  back_op  = CELL_LOAD;
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  err = ERR_FULL;
               end else begin
                  front_op = CELL_LOAD;
                  back_op  = CELL_SHIFT_UP;
                  count_in = count_ff + CW'(1);
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  err = ERR_EMPTY;
               end else begin
                  front_op = CELL_SHIFT_DOWN;
                  popped   = front_q;
                  count_in = count_ff - CW'(1);
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  err = ERR_EMPTY;
               end else begin
                  back_op  = CELL_SHIFT_DOWN;
                  popped   = back_q;
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               err = ERR_OK;
            end
         endcase
      end
   end

   deq_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW)
   ) u_front_chain (
      .clock  (clock),
      .op     (front_op),
      .count  (count_ff),
      .word   (word),
      .head_q (front_q),
      .head_d (front_d)
   );

   deq_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW)
   ) u_back_chain (
      .clock  (clock),
      .op     (back_op),
      .count  (count_ff),
      .word   (word),
      .head_q (back_q),
      .head_d (back_d)
   );

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_valid_in        = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in         = 1'b1;
         rsp_in.popped_value  = WORD_BITS'(popped);
         rsp_in.front_value   = (count_in != '0) ? WORD_BITS'(front_d) : '0;
         rsp_in.back_value    = (count_in != '0) ? WORD_BITS'(back_d) : '0;
         rsp_in.is_empty      = (count_in == '0);
         rsp_in.entry_count   = COUNT_BITS'(count_in);
         rsp_in.error_code    = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: dv/double_ended_queue_test.sv
// double_ended_queue_test: self-checking bench for the double-ended queue
// drives push/pop items with bursty valid, stalls results, checks each against a ring predictor
// depends on deq_pkg and double_ended_queue
`timescale 1ns / 1ps

module double_ended_queue_test;
   import deq_pkg::*;

   localparam int RING_SLOTS   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 550;
   localparam int DRAIN_EVERY  = 200;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 8;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_items[$];
   rsp_type expected_results[$];

   // predictor state
   logic [WORD_BITS-1:0] ring_words [RING_SLOTS];
   int head_slot  = 0;
   int fill_count = 0;

   int failures       = 0;
   int total_items    = 0;
   int accepted_count = 0;
   int received_count = 0;

   // driver pacing
   int  burst_left = 1;
   int  gap_left   = 0;
   bit  drain_hold = 1'b0;

   // receiver pacing
   int  stall_mode   = 0;
   int  pattern_left = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   int  cycle_count  = 0;

   double_ended_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic queue_item(input cmd_type cmd, input logic [WORD_BITS-1:0] word);
      req_type item;
      item.cmd     = cmd;
      item.data_in = word;
      pending_items.push_back(item);
   endtask

   task automatic predict_result(input req_type item);
      rsp_type outcome;
      outcome = '0;
      outcome.error_code = ERR_OK;
      case (item.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (fill_count >= RING_SLOTS) begin
               outcome.error_code = ERR_FULL;
            end else if (item.cmd == CMD_PUSH_FRONT) begin
               head_slot = (head_slot + RING_SLOTS - 1) % RING_SLOTS;
               ring_words[head_slot] = item.data_in;
               fill_count++;
            end else begin
               ring_words[(head_slot + fill_count) % RING_SLOTS] = item.data_in;
               fill_count++;
            end
         end
         default: begin
            if (fill_count == 0) begin
               outcome.error_code = ERR_EMPTY;
            end else if (item.cmd == CMD_POP_FRONT) begin
               outcome.popped_value = ring_words[head_slot];
               head_slot = (head_slot + 1) % RING_SLOTS;
               fill_count--;
            end else begin
               outcome.popped_value = ring_words[(head_slot + fill_count - 1) % RING_SLOTS];
               fill_count--;
            end
         end
      endcase
      if (fill_count != 0) begin
         outcome.front_value = ring_words[head_slot];
         outcome.back_value  = ring_words[(head_slot + fill_count - 1) % RING_SLOTS];
      end
      outcome.is_empty    = (fill_count == 0);
      outcome.entry_count = fill_count[COUNT_BITS-1:0];
      expected_results.push_back(outcome);
   endtask

   task automatic check_field(input string field, input logic [WORD_BITS-1:0] want,
                              input logic [WORD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         failures++;
      end
   endtask

   // driver
   always @(posedge clock) begin : driver
      bit offer;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_result(req_data);
            accepted_count++;
            if (accepted_count % DRAIN_EVERY == 0) begin
               drain_hold = 1'b1;
            end
         end
         if (!(req_valid && req_stall)) begin
            if (drain_hold && expected_results.size() != 0) begin
               offer = 1'b0;
            end else begin
               drain_hold = 1'b0;
               if (gap_left > 0) begin
                  gap_left--;
               end else if (pending_items.size() != 0) begin
                  offer = 1'b1;
                  burst_left--;
                  if (burst_left <= 0) begin
                     burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
                     gap_left   = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 8);
                  end
               end
            end
            req_valid <= offer;
            if (offer) begin
               req_data <= pending_items.pop_front();
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin : receiver
      bit stall_next;
      stall_next = 1'b0;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!hold_done && received_count >= HOLD_AT) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES;
            stall_next = 1'b1;
         end else begin
            if (pattern_left <= 0) begin
               stall_mode   = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 100);
            end
            pattern_left--;
            case (stall_mode)
               0:       stall_next = 1'b0;
               1:       stall_next = ($urandom_range(0, 3) == 0);
               2:       stall_next = ($urandom_range(0, 3) != 0);
               default: stall_next = cycle_count[0];
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         received_count++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("popped_value", want.popped_value, rsp_data.popped_value);
            check_field("front_value", want.front_value, rsp_data.front_value);
            check_field("back_value", want.back_value, rsp_data.back_value);
            check_field("is_empty", WORD_BITS'(want.is_empty),
                        WORD_BITS'(rsp_data.is_empty));
            check_field("entry_count", WORD_BITS'(want.entry_count),
                        WORD_BITS'(rsp_data.entry_count));
            check_field("error_code", WORD_BITS'(want.error_code),
                        WORD_BITS'(rsp_data.error_code));
         end
      end
   end

   initial begin : stimulus
      int made;
      int seg_len;
      int push_pct;
      bit is_push;
      bit at_front;
      logic [WORD_BITS-1:0] word;

      // directed: empty pops, extremes, fill to full with front wrap, overflow
      queue_item(CMD_POP_FRONT, 32'hFFFF_FFFF);
      queue_item(CMD_POP_BACK, 32'h0000_0000);
      queue_item(CMD_PUSH_FRONT, 32'h0000_0000);
      queue_item(CMD_PUSH_BACK, 32'hFFFF_FFFF);
      queue_item(CMD_POP_FRONT, 32'h0000_0000);
      queue_item(CMD_POP_BACK, 32'hFFFF_FFFF);
      for (int i = 0; i < RING_SLOTS; i++) begin
         queue_item(cmd_type'(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT), 32'hA5A5_0000 | i);
      end
      queue_item(CMD_PUSH_FRONT, 32'h1234_5678);
      queue_item(CMD_PUSH_BACK, 32'h8765_4321);

      // random: segments biased toward filling, draining or churn
      made = 0;
      while (made < RANDOM_ITEMS) begin
         seg_len = $urandom_range(8, 48);
         case ($urandom_range(0, 2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         for (int k = 0; k < seg_len && made < RANDOM_ITEMS; k++) begin
            is_push  = ($urandom_range(0, 99) < push_pct);
            at_front = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
               0:       word = '0;
               1:       word = '1;
               2:       word = 32'h1 << $urandom_range(0, 31);
               default: word = $urandom;
            endcase
            if (is_push) begin
               queue_item(cmd_type'(at_front ? CMD_PUSH_FRONT : CMD_PUSH_BACK), word);
            end else begin
               queue_item(cmd_type'(at_front ? CMD_POP_FRONT : CMD_POP_BACK), word);
            end
            made++;
         end
      end
      total_items = pending_items.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (failures == 0 && expected_results.size() == 0) begin
         $display("double_ended_queue_test passed");
      end else begin
         $display("double_ended_queue_test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("double_ended_queue_test failed");
      $finish;
   end

endmodule
